// ===== hw/rtl/thick_stroke_rasterizer_unit_macros.svh =====
// Assertion helpers for the stroke rasterizer.
`ifndef THICK_STROKE_RASTERIZER_UNIT_MACROS_SVH
`define THICK_STROKE_RASTERIZER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsr check failed");
// Implication whose consequence is checked in the next cycle.
`define TSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsr check failed");
`endif

// ===== hw/rtl/tsr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants of the thick stroke rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tsr_pkg;
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_STROKE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] CFG_SCALE    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_X = 2'd1;
    localparam logic [1:0] CFG_OFFSET_Y = 2'd2;
    localparam logic [1:0] CFG_PAPER    = 2'd3;

    localparam logic [15:0] PAPER_RESET = 16'hFFDF;
    localparam logic [11:0] SCALE_ONE   = 12'd256;

    // Screen coordinates are kept at 32 bits signed.
    localparam int CW = 32;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;    // latch the input item
        logic map_x;      // compute mapped x product
        logic map_y;      // compute mapped y product
        logic map_fin;    // round the y product, compute radius
        logic line_init;  // set up the Bresenham walk
        logic disc_init;  // start a disc at the current point
        logic disc_step;  // advance the disc scan
        logic line_step;  // advance the Bresenham walk
        logic finish;     // store last point
        logic clr_init;   // start the clear sweep
        logic clr_step;   // advance the clear sweep
        logic rd_issue;   // issue a pixel read
        logic rd_load;    // load read data to output
    } tsr_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] mode;
        logic       single;     // stamp one disc only
        logic       disc_skip;  // disc wholly off screen
        logic       disc_last;  // scan at its final offset
        logic       line_last;  // walk reached end point
        logic       clr_last;   // sweep at last address
    } tsr_stat_t;
endpackage

// ===== hw/rtl/tsr_ram.sv =====
// ----------------------------------------------------------------------------
// tsr_ram
// Single port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 76800
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/tsr_datapath.sv =====
// ----------------------------------------------------------------------------
// tsr_datapath
// Viewport mapping, line walk, disc scan, clear sweep and frame store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tsr_datapath #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int MAX_RADIUS    = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tsr_pkg::tsr_cmd_t cmd,
    output tsr_pkg::tsr_stat_t stat,
    input  logic [1:0]        mode,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic              stroke_start,
    input  logic [7:0]        brush_width,
    input  logic [15:0]       ink_color,
    input  logic [8:0]        pixel_x,
    input  logic [7:0]        pixel_y,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_idx,
    input  logic [23:0]       cfg_data,
    output logic [15:0]       pixel_value
);
    import tsr_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_RADIUS + 1) + 1;  // signed radius offsets
    localparam logic signed [CW-1:0] SW = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] SH = CW'(SCREEN_HEIGHT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [11:0] scale_reg;
    logic signed [23:0] offx_reg, offy_reg;
    logic [15:0] paper_reg;

    logic [1:0] mode_reg;
    logic signed [15:0] px_reg, py_reg;
    logic start_reg;
    logic [7:0] bw_reg;
    logic [15:0] col_reg;
    logic [8:0] rx_reg;
    logic [7:0] ry_reg;

    logic signed [CW-1:0] lastx_reg, lasty_reg;
    logic have_reg;
    logic signed [47:0] prod_reg, prod_next;
    logic signed [CW-1:0] nx_reg, ny_reg;
    logic [RW-1:0] r_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, err_reg;
    logic signed [CW-1:0] adx_reg, ady_reg;
    logic stx_reg, sty_reg;
    logic signed [RW-1:0] ddx_reg, ddy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [15:0] pix_reg;

    logic [11:0] eff_scale;
    assign eff_scale = (scale_reg == 12'd0) ? SCALE_ONE : scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_ONE;
            offx_reg  <= '0;
            offy_reg  <= '0;
            paper_reg <= PAPER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_SCALE:    scale_reg <= cfg_data[11:0];
                CFG_OFFSET_X: offx_reg  <= cfg_data;
                CFG_OFFSET_Y: offy_reg  <= cfg_data;
                CFG_PAPER:    paper_reg <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Mapping: ((p*256 - off) * s), rounded by 2^16 halves away from zero.
    logic signed [25:0] diff;
    logic signed [CW-1:0] rnd;
    logic [47:0] mag;
    always_comb
    begin
        diff = 26'(signed'(cmd.map_x ? px_reg : py_reg)) * 26'sd256
             - 26'(cmd.map_x ? offx_reg : offy_reg);
        prod_next = 48'(diff) * signed'({36'd0, eff_scale});
        mag = prod_reg[47] ? 48'(-prod_reg) : 48'(prod_reg);
        mag = (mag + 48'd32768) >> 16;
        rnd = prod_reg[47] ? -CW'(mag) : CW'(mag);
    end

    // Radius from brush width.
    logic [19:0] thick;
    logic [18:0] half;
    logic [RW-1:0] rad;
    always_comb
    begin
        thick = (20'(bw_reg) * 20'(eff_scale) + 20'd128) >> 8;
        if (thick == 20'd0)
        begin
            thick = 20'd1;
        end
        half = thick[19:1];
        rad = (half > 19'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(half);
    end

    logic signed [CW-1:0] rs, px, py, e2, lim, d2;
    logic signed [CW-1:0] ddx_w, ddy_w;
    logic in_scr;
    logic [AW-1:0] wr_addr, rd_addr, addr;
    logic we;
    always_comb
    begin
        rs    = CW'(r_reg);
        ddx_w = CW'(ddx_reg);
        ddy_w = CW'(ddy_reg);
        px    = cx_reg + ddx_w;
        py    = cy_reg + ddy_w;
        lim   = rs * rs + rs;
        d2    = ddx_w * ddx_w + ddy_w * ddy_w;
        e2    = err_reg <<< 1;
        in_scr = (px >= 0) && (py >= 0) && (px < SW) && (py < SH) && (d2 <= lim);
        wr_addr = AW'(py) * AW'(SCREEN_WIDTH) + AW'(px);
        rd_addr = AW'(ry_reg) * AW'(SCREEN_WIDTH) + AW'(rx_reg);
        we = cmd.clr_step || (cmd.disc_step && in_scr);
        if (cmd.clr_step)
        begin
            addr = clr_addr_reg;
        end
        else if (cmd.disc_step)
        begin
            addr = wr_addr;
        end
        else
        begin
            addr = rd_addr;
        end
    end

    logic [15:0] rdata;
    tsr_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (cmd.clr_step ? paper_reg : col_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        stat.mode      = mode_reg;
        stat.single    = start_reg || !have_reg;
        stat.disc_skip = (cx_reg < -rs) || (cx_reg >= SW + rs)
                      || (cy_reg < -rs) || (cy_reg >= SH + rs);
        stat.disc_last = (ddx_reg == signed'(r_reg)) && (ddy_reg == signed'(r_reg));
        stat.line_last = (cx_reg == nx_reg) && (cy_reg == ny_reg);
        stat.clr_last  = (clr_addr_reg == LAST_ADDR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lastx_reg <= '0;
            lasty_reg <= '0;
            have_reg  <= 1'b0;
            mode_reg  <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                mode_reg <= mode;
            end
            if (cmd.finish)
            begin
                lastx_reg <= nx_reg;
                lasty_reg <= ny_reg;
                have_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            start_reg <= stroke_start;
            bw_reg <= brush_width;
            col_reg <= ink_color;
            rx_reg <= pixel_x;
            ry_reg <= pixel_y;
        end
        if (cmd.map_x || cmd.map_y)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.map_y)
        begin
            nx_reg <= rnd;
        end
        if (cmd.map_fin)
        begin
            ny_reg <= rnd;
            r_reg  <= rad;
        end
        if (cmd.line_init)
        begin
            if (start_reg || !have_reg)
            begin
                cx_reg <= nx_reg;
                cy_reg <= ny_reg;
            end
            else
            begin
                cx_reg <= lastx_reg;
                cy_reg <= lasty_reg;
            end
            adx_reg <= (nx_reg > lastx_reg) ? nx_reg - lastx_reg : lastx_reg - nx_reg;
            ady_reg <= -((ny_reg > lasty_reg) ? ny_reg - lasty_reg : lasty_reg - ny_reg);
            err_reg <= ((nx_reg > lastx_reg) ? nx_reg - lastx_reg : lastx_reg - nx_reg)
                     - ((ny_reg > lasty_reg) ? ny_reg - lasty_reg : lasty_reg - ny_reg);
            stx_reg <= lastx_reg < nx_reg;
            sty_reg <= lasty_reg < ny_reg;
        end
        if (cmd.line_step)
        begin
            if (e2 >= ady_reg && e2 <= adx_reg)
            begin
                err_reg <= err_reg + ady_reg + adx_reg;
            end
            else if (e2 >= ady_reg)
            begin
                err_reg <= err_reg + ady_reg;
            end
            else if (e2 <= adx_reg)
            begin
                err_reg <= err_reg + adx_reg;
            end
            if (e2 >= ady_reg)
            begin
                cx_reg <= stx_reg ? cx_reg + 1 : cx_reg - 1;
            end
            if (e2 <= adx_reg)
            begin
                cy_reg <= sty_reg ? cy_reg + 1 : cy_reg - 1;
            end
        end
        if (cmd.disc_init)
        begin
            ddx_reg <= -signed'(r_reg);
            ddy_reg <= -signed'(r_reg);
        end
        else if (cmd.disc_step)
        begin
            if (ddx_reg == signed'(r_reg))
            begin
                ddx_reg <= -signed'(r_reg);
                ddy_reg <= ddy_reg + RW'(1);
            end
            else
            begin
                ddx_reg <= ddx_reg + RW'(1);
            end
        end
        if (cmd.clr_init)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
        if (cmd.rd_load)
        begin
            pix_reg <= (32'(rx_reg) < 32'(SCREEN_WIDTH) && 32'(ry_reg) < 32'(SCREEN_HEIGHT))
                     ? rdata : 16'd0;
        end
    end

    assign pixel_value = pix_reg;
endmodule

// ===== hw/rtl/tsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsr_ctrl
// Sequencer for clear, stroke and read items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tsr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output tsr_pkg::tsr_cmd_t  cmd,
    input  tsr_pkg::tsr_stat_t stat
);
    import tsr_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DEC   = 12'b000000000010,
        S_MAPX  = 12'b000000000100,
        S_MAPY  = 12'b000000001000,
        S_MAPF  = 12'b000000010000,
        S_LINIT = 12'b000000100000,
        S_DINIT = 12'b000001000000,
        S_DISC  = 12'b000010000000,
        S_LSTEP = 12'b000100000000,
        S_CLR   = 12'b001000000000,
        S_RD    = 12'b010000000000,
        S_RDW   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        // a waiting result only holds a later read in S_RDW
        in_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (stat.mode)
                    MODE_CLEAR:
                    begin
                        cmd.clr_init = 1'b1;
                        state_next = S_CLR;
                    end
                    MODE_STROKE: state_next = S_MAPX;
                    MODE_READ:   state_next = S_RD;
                    default:     state_next = S_IDLE;
                endcase
            end
            S_MAPX:
            begin
                cmd.map_x = 1'b1;
                state_next = S_MAPY;
            end
            S_MAPY:
            begin
                cmd.map_y = 1'b1;
                state_next = S_MAPF;
            end
            S_MAPF:
            begin
                cmd.map_fin = 1'b1;
                state_next = S_LINIT;
            end
            S_LINIT:
            begin
                cmd.line_init = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.disc_init = 1'b1;
                state_next = S_DISC;
            end
            S_DISC:
            begin
                if (stat.disc_skip || stat.disc_last)
                begin
                    cmd.disc_step = !stat.disc_skip;
                    if (stat.single || stat.line_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LSTEP;
                    end
                end
                else
                begin
                    cmd.disc_step = 1'b1;
                end
            end
            S_LSTEP:
            begin
                cmd.line_step = 1'b1;
                state_next = S_DINIT;
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                if (!ov_reg)
                begin
                    cmd.rd_load = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;
endmodule

// ===== hw/rtl/thick_stroke_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// thick_stroke_rasterizer_unit
// Thick stroke rasterizer with an owned RGB565 frame store.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (tdata low bit up)
// s_axis    in   tdata: mode, point_x, point_y, brush_width, ink_color,
//                pixel_x, pixel_y; tuser: stroke_start
// m_axis    out  tdata: pixel_value
// cfg       in   cfg_we / cfg_index / cfg_data
//
// A clear sweeps the whole store; a stroke stamps one disc per line point, and
// a disc wholly off screen is skipped without scanning its square.
// The single frame store port takes one pixel per cycle.
// After reset the store is filled with the reset paper color by a sweep,
// during which no transaction is accepted.
// One item at a time; a read result waits in the output register while later
// items run; a further read holds in its last cycle until the result is taken.
`timescale 1ns / 1ps
module thick_stroke_rasterizer_unit #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int MAX_RADIUS    = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0], point_x[17:2], point_y[33:18], brush_width[41:34],
    // ink_color[57:42], pixel_x[66:58], pixel_y[74:67], zero fill
    input  logic [79:0] s_axis_tdata,
    // stroke_start
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_value
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import tsr_pkg::*;

    tsr_cmd_t  cmd, cmd_c;
    tsr_stat_t stat;
    logic boot_reg;   // reset fill sweep in progress
    logic ctrl_ready;

    // Reset sweep: reuse the clear path before handing control over.
    logic boot_first_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_reg <= 1'b1;
            boot_first_reg <= 1'b1;
        end
        else if (boot_reg)
        begin
            boot_first_reg <= 1'b0;
            if (!boot_first_reg && stat.clr_last)
            begin
                boot_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        cmd = cmd_c;
        if (boot_reg)
        begin
            cmd = '0;
            cmd.clr_init = boot_first_reg;
            cmd.clr_step = !boot_first_reg;
        end
    end

    tsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n && !boot_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (ctrl_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd_c),
        .stat      (stat)
    );
    assign s_axis_tready = ctrl_ready && !boot_reg;

    tsr_datapath #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .MAX_RADIUS   (MAX_RADIUS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (s_axis_tdata[1:0]),
        .point_x      (s_axis_tdata[17:2]),
        .point_y      (s_axis_tdata[33:18]),
        .stroke_start (s_axis_tuser),
        .brush_width  (s_axis_tdata[41:34]),
        .ink_color    (s_axis_tdata[57:42]),
        .pixel_x      (s_axis_tdata[66:58]),
        .pixel_y      (s_axis_tdata[74:67]),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_value  (m_axis_tdata)
    );
endmodule

// ===== hw/rtl/tsr_checker.sv =====
// ----------------------------------------------------------------------------
// tsr_checker
// Port level checks of the stroke rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "thick_stroke_rasterizer_unit_macros.svh"
module tsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    `TSR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `TSR_ASSERT_IMP(a_out_known, clk, rst_n, m_axis_tvalid, !$isunknown(m_axis_tdata))
    `TSR_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind thick_stroke_rasterizer_unit tsr_checker u_tsr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/stroke_checker.sv =====
// ----------------------------------------------------------------------------
// stroke_checker
// Watches the rasterizer channels, predicts every pixel read and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stroke_checker #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int MAX_RADIUS    = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          errors,
    output int          pending
);
    import tsr_pkg::*;

    localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

    logic [15:0] canvas_mem [0:PIXELS-1];
    logic [15:0] pixel_expect [$];

    logic [11:0] scale_reg;
    logic signed [23:0] offx_reg;
    logic signed [23:0] offy_reg;
    logic [15:0] paper_reg;
    int  last_x;
    int  last_y;
    bit  have_last;

    function automatic longint eff_scale();
        return (scale_reg == 0) ? 256 : longint'(scale_reg);
    endfunction

    // round((p*256 - off) * s / 65536), halves away from zero
    function automatic int map_to_screen(longint p, longint off);
        longint num;
        num = (p * 256 - off) * eff_scale();
        if (num >= 0)
            return int'((num + 32768) >>> 16);
        return -int'((-num + 32768) >>> 16);
    endfunction

    task automatic fill_canvas(logic [15:0] col);
        for (int i = 0; i < PIXELS; i++)
            canvas_mem[i] = col;
    endtask

    task automatic stamp_disc(longint cx, longint cy, int r, logic [15:0] col);
        longint lim;
        longint x;
        longint y;
        lim = longint'(r) * r + r;
        if (cx < -r || cx >= SCREEN_WIDTH + r || cy < -r || cy >= SCREEN_HEIGHT + r)
            return;
        for (int dy = -r; dy <= r; dy++)
            for (int dx = -r; dx <= r; dx++) begin
                x = cx + dx;
                y = cy + dy;
                if (longint'(dx) * dx + longint'(dy) * dy <= lim &&
                    x >= 0 && y >= 0 && x < SCREEN_WIDTH && y < SCREEN_HEIGHT)
                    canvas_mem[y * SCREEN_WIDTH + x] = col;
            end
    endtask

    task automatic draw_stroke_point(logic [79:0] d, logic start);
        longint px;
        longint py;
        longint thick;
        int r;
        int nx;
        int ny;
        longint x0, y0, x1, y1, adx, ady, stx, sty, err, e2;
        logic [15:0] col;
        px = longint'($signed(d[17:2]));
        py = longint'($signed(d[33:18]));
        col = d[57:42];
        thick = (longint'(d[41:34]) * eff_scale() + 128) >>> 8;
        if (thick < 1)
            thick = 1;
        r = int'(thick / 2);
        if (r > MAX_RADIUS)
            r = MAX_RADIUS;
        nx = map_to_screen(px, longint'(offx_reg));
        ny = map_to_screen(py, longint'(offy_reg));
        if (start || !have_last)
            stamp_disc(nx, ny, r, col);
        else begin
            x0 = last_x;
            y0 = last_y;
            x1 = nx;
            y1 = ny;
            adx = (x1 > x0) ? x1 - x0 : x0 - x1;
            ady = -((y1 > y0) ? y1 - y0 : y0 - y1);
            stx = (x0 < x1) ? 1 : -1;
            sty = (y0 < y1) ? 1 : -1;
            err = adx + ady;
            forever begin
                stamp_disc(x0, y0, r, col);
                if (x0 == x1 && y0 == y1)
                    break;
                e2 = 2 * err;
                if (e2 >= ady) begin
                    err += ady;
                    x0 += stx;
                end
                if (e2 <= adx) begin
                    err += adx;
                    y0 += sty;
                end
            end
        end
        last_x = nx;
        last_y = ny;
        have_last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [8:0] rx;
        logic [7:0] ry;
        logic [15:0] want;
        if (!rst_n) begin
            scale_reg = SCALE_ONE;
            offx_reg  = '0;
            offy_reg  = '0;
            paper_reg = PAPER_RESET;
            last_x    = 0;
            last_y    = 0;
            have_last = 1'b0;
            fill_canvas(PAPER_RESET);
            pixel_expect.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCALE:    scale_reg = cfg_data[11:0];
                    CFG_OFFSET_X: offx_reg  = cfg_data;
                    CFG_OFFSET_Y: offy_reg  = cfg_data;
                    CFG_PAPER:    paper_reg = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tdata[1:0])
                    MODE_CLEAR:  fill_canvas(paper_reg);
                    MODE_STROKE: draw_stroke_point(s_axis_tdata, s_axis_tuser);
                    MODE_READ: begin
                        rx = s_axis_tdata[66:58];
                        ry = s_axis_tdata[74:67];
                        want = 16'd0;
                        if (rx < SCREEN_WIDTH && ry < SCREEN_HEIGHT)
                            want = canvas_mem[ry * SCREEN_WIDTH + rx];
                        pixel_expect = {pixel_expect, want};
                        pending++;
                    end
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixel_expect.size() == 0) begin
                    $error("pixel_value: unexpected transaction, got %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = pixel_expect.pop_front();
                    pending--;
                    if (m_axis_tdata !== want) begin
                        $error("pixel_value mismatch: expected %h, got %h",
                               want, m_axis_tdata);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the thick stroke rasterizer.
// Directed corner items, then six viewport settings each with a random mix of
// connected strokes, stray points, clears, reads and unused-mode items; stroke_checker predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
    import tsr_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 250;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // mode, point_x, point_y, brush_width, ink_color, pixel_x, pixel_y, zero fill
    logic [79:0] s_axis_tdata;
    // stroke_start
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // pixel_value
    logic [15:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    int errors;
    int pending;

    // no idling at all while calm is set
    bit calm;
    int stall_left;

    // local copy of the viewport, used only to aim and size strokes
    longint vp_scale;
    longint vp_offx;
    longint vp_offy;
    int cur_sx;
    int cur_sy;
    bit force_start;

    int n_strokes;
    int n_reads;
    int n_clears;
    int n_other;

    thick_stroke_rasterizer_unit dut (.*);

    stroke_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #300_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 99)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver stalls: mostly short, a few long
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one transaction; valid stays high across back-to-back items
    task automatic send_item(logic [1:0] mode, logic [15:0] px, logic [15:0] py,
                             logic start, logic [7:0] bw, logic [15:0] ink,
                             logic [8:0] rx, logic [7:0] ry);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {5'd0, ry, rx, ink, bw, py, px, mode};
        s_axis_tuser  <= start;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        case (mode)
            MODE_CLEAR:  n_clears++;
            MODE_STROKE: n_strokes++;
            MODE_READ:   n_reads++;
            default:     n_other++;
        endcase
    endtask

    task automatic read_pixel(int x, int y);
        send_item(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, x, y);
    endtask

    // canvas coordinate that lands near screen coordinate s; flags clamping
    function automatic longint aim(int s, longint off, output bit clamped);
        longint p;
        p = (off + (longint'(s) * 65536) / vp_scale) / 256;
        clamped = 1'b0;
        if (p > 32767) begin
            p = 32767;
            clamped = 1'b1;
        end
        if (p < -32768) begin
            p = -32768;
            clamped = 1'b1;
        end
        return p;
    endfunction

    task automatic random_stroke(bit start);
        longint px;
        longint py;
        bit cx;
        bit cy;
        int max_w;
        if (start) begin
            cur_sx = $urandom_range(0, 359) - 20;
            cur_sy = $urandom_range(0, 279) - 20;
        end else begin
            cur_sx += $urandom_range(0, 12) - 6;
            cur_sy += $urandom_range(0, 12) - 6;
            if (cur_sx < -40) cur_sx = -40;
            if (cur_sx > 360) cur_sx = 360;
            if (cur_sy < -40) cur_sy = -40;
            if (cur_sy > 280) cur_sy = 280;
        end
        px = aim(cur_sx, vp_offx, cx);
        py = aim(cur_sy, vp_offy, cy);
        // a clamped point may map far away: never walk a line to or from it
        start = start | force_start | cx | cy;
        force_start = cx | cy;
        // keep discs small so that each step stays cheap
        max_w = 2048 / vp_scale;
        if (max_w > 255) max_w = 255;
        send_item(MODE_STROKE, px, py, start, $urandom_range(0, max_w), $urandom,
                  $urandom, $urandom);
    endtask

    task automatic random_item();
        int roll;
        roll = $urandom_range(0, 999);
        if (roll < 3)
            send_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        else if (roll < 30) begin
            // stray point anywhere, full width range, single disc
            send_item(MODE_STROKE, $urandom, $urandom, 1'b1, $urandom, $urandom,
                      $urandom, $urandom);
            force_start = 1'b1;
        end else if (roll < 60)
            send_item(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        else if (roll < 140)
            random_stroke(1'b1);
        else if (roll < 560)
            random_stroke(1'b0);
        else if (roll < 940)
            read_pixel($urandom_range(0, 319), $urandom_range(0, 239));
        else
            read_pixel($urandom_range(0, 511), $urandom_range(0, 255));
    endtask

    // a read drains the block; once its result is in, registers may change
    task automatic drain();
        read_pixel($urandom_range(0, 319), $urandom_range(0, 239));
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic set_view(longint sc, longint ox, longint oy, logic [15:0] paper);
        write_reg(CFG_SCALE, sc);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_PAPER, paper);
        vp_scale = (sc == 0) ? 256 : sc;
        vp_offx = ox;
        vp_offy = oy;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SCALE;
        cfg_data  = '0;
        calm = 1'b0;
        vp_scale = 256;
        vp_offx = 0;
        vp_offy = 0;
        cur_sx = 160;
        cur_sy = 120;
        force_start = 1'b1;
        n_strokes = 0;
        n_reads = 0;
        n_clears = 0;
        n_other = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: screen corners, reads off screen, unused mode
        read_pixel(0, 0);
        read_pixel(319, 239);
        read_pixel(320, 0);
        read_pixel(511, 255);
        send_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 16'h1234, 9'd0, 8'd0);
        // continuation with no previous point draws a single disc
        send_item(MODE_STROKE, 16'd10, 16'd10, 1'b0, 8'd0, 16'hF800, '0, '0);
        read_pixel(10, 10);
        // coordinate extremes, disc wholly off screen
        send_item(MODE_STROKE, 16'h8000, 16'h7FFF, 1'b1, 8'd4, 16'h07E0, '0, '0);
        send_item(MODE_STROKE, 16'h7FFF, 16'h8000, 1'b1, 8'd4, 16'h07E0, '0, '0);
        // widest brush, saturated radius, clipped at the corner
        send_item(MODE_STROKE, 16'd0, 16'd0, 1'b1, 8'hFF, 16'h001F, '0, '0);
        read_pixel(21, 21);
        read_pixel(31, 0);
        // short thick line across the screen edge
        send_item(MODE_STROKE, 16'd300, 16'd230, 1'b1, 8'd6, 16'hFFFF, '0, '0);
        send_item(MODE_STROKE, 16'd325, 16'd245, 1'b0, 8'd6, 16'hFFFF, '0, '0);
        read_pixel(319, 239);
        read_pixel(310, 236);
        // clear keeps the last point: next line continues from it
        send_item(MODE_CLEAR, '0, '0, 1'b0, '0, '0, '0, '0);
        read_pixel(310, 236);
        send_item(MODE_STROKE, 16'd315, 16'd238, 1'b0, 8'd1, 16'h0000, '0, '0);
        read_pixel(319, 239);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: set_view(0, 24'h000A00, -24'sd1280, 16'h0000);
                2: set_view(4095, 24'h000300, 24'h000180, 16'hFFFF);
                3: set_view(1, 24'h7FFFFF, -8388608, $urandom);
                4: set_view(512, 24'h000000, 24'h000000, $urandom);
                5: set_view(128, -8388608, 24'h7FFFFF, $urandom);
                default: ;
            endcase
            calm = (ph == 4);
            force_start = 1'b1;
            if (ph > 0)
                send_item(MODE_CLEAR, '0, '0, 1'b0, '0, '0, '0, '0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                random_item();
            drain();
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Covered %0d strokes, %0d reads, %0d clears, %0d ignored items",
                 n_strokes, n_reads, n_clears, n_other);
        $display("over %0d viewport settings including scale extremes", PHASES);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
